FILE: rtl/ppes_pkg.sv
package ppes_pkg;

    localparam int unsigned MAX_POINTS_PER_LINE = 1024;
    localparam int unsigned MAX_LINES           = 4096;

    localparam int unsigned COORD_W  = 24;
    localparam int unsigned DIFF_W   = 25;
    localparam int unsigned GSD_W    = 24;
    localparam int unsigned LSUM_W   = 40;
    localparam int unsigned LCNT_W   = 11;
    localparam int unsigned SSUM_W   = 48;
    localparam int unsigned SQSUM_W  = 64;
    localparam int unsigned SCNT_W   = 13;
    localparam int unsigned MEAN_W   = 47;
    localparam int unsigned ACC_W    = 98;
    localparam int unsigned DIVN_W   = 80;
    localparam int unsigned DIVD_W   = 26;
    localparam int unsigned RAD_W    = 64;
    localparam int unsigned ROOT_W   = 32;
    localparam int unsigned VAL_W    = 48;
    localparam int unsigned CNT_OUT_W = 47;

    localparam logic [GSD_W-1:0] GSD_RESET = 24'd65536;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_SET   = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_PMX,
        CMD_PMY,
        CMD_PMA,
        CMD_PSQRT,
        CMD_PEMIT,
        CMD_LM0,
        CMD_LM1,
        CMD_LM2,
        CMD_LDIV,
        CMD_LMEAN,
        CMD_LSQ,
        CMD_LEMIT,
        CMD_SDIV,
        CMD_SMEAN,
        CMD_SNN,
        CMD_SP0,
        CMD_SP1,
        CMD_SP2,
        CMD_SS1,
        CMD_SS2,
        CMD_SS3,
        CMD_SDIV2,
        CMD_SSQRT,
        CMD_SEMIT
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PMX,
        ST_PMY,
        ST_PMA,
        ST_PSQ,
        ST_PWAIT,
        ST_PEMIT,
        ST_LM0,
        ST_LM1,
        ST_LM2,
        ST_LDIV,
        ST_LWAIT,
        ST_LMEAN,
        ST_LSQ,
        ST_LEMIT,
        ST_SDIV,
        ST_SWAIT,
        ST_SMEAN,
        ST_SNN,
        ST_SP0,
        ST_SP1,
        ST_SP2,
        ST_SS1,
        ST_SS2,
        ST_SS3,
        ST_SDIV2,
        ST_SWAIT2,
        ST_SSQ,
        ST_SWAIT3,
        ST_SEMIT
    } state_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic out_busy;
        logic eol;
        logic eos;
    } dp_status_t;

endpackage

FILE: rtl/ppes_div.sv
module ppes_div
    import ppes_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVN_W-1:0] dividend,
    input  logic [DIVD_W-1:0] divisor,
    output logic              done,
    output logic [DIVN_W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(DIVN_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] d_reg, d_next;
    logic [DIVN_W-1:0] nq_reg, nq_next;
    logic [DIVD_W:0]   trial;
    logic              ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial     = {rem_reg, nq_reg[DIVN_W-1]};
        ge        = trial >= {1'b0, d_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        nq_next   = nq_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            d_next    = divisor;
            nq_next   = dividend;
        end else if (busy_reg) begin
            rem_next = ge ? DIVD_W'(trial - {1'b0, d_reg}) : trial[DIVD_W-1:0];
            nq_next  = {nq_reg[DIVN_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVN_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        d_reg   <= d_next;
        nq_reg  <= nq_next;
    end

    assign done     = done_reg;
    assign quotient = nq_reg;

endmodule

FILE: rtl/ppes_sqrt.sv
module ppes_sqrt
    import ppes_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int unsigned CNT_W = $clog2(ROOT_W);
    localparam int unsigned REM_W = ROOT_W + 2;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic              ge;

    // one root bit per cycle, two radicand bits shifted in
    always_comb begin
        cur       = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial     = {2'b00, root_reg, 2'b01};
        ge        = cur >= trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            rad_next  = radicand;
            root_next = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: rtl/ppes_ctrl.sv
module ppes_ctrl
    import ppes_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NOP;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = ST_PMX;
                end
            end
            ST_PMX: begin cmd = CMD_PMX;   state_next = ST_PMY; end
            ST_PMY: begin cmd = CMD_PMY;   state_next = ST_PMA; end
            ST_PMA: begin cmd = CMD_PMA;   state_next = ST_PSQ; end
            ST_PSQ: begin cmd = CMD_PSQRT; state_next = ST_PWAIT; end
            ST_PWAIT: begin
                if (status.sqrt_done) state_next = ST_PEMIT;
            end
            ST_PEMIT: begin
                if (!status.out_busy) begin
                    cmd        = CMD_PEMIT;
                    state_next = status.eol ? ST_LM0 : ST_IDLE;
                end
            end
            ST_LM0:  begin cmd = CMD_LM0;  state_next = ST_LM1; end
            ST_LM1:  begin cmd = CMD_LM1;  state_next = ST_LM2; end
            ST_LM2:  begin cmd = CMD_LM2;  state_next = ST_LDIV; end
            ST_LDIV: begin cmd = CMD_LDIV; state_next = ST_LWAIT; end
            ST_LWAIT: begin
                if (status.div_done) state_next = ST_LMEAN;
            end
            ST_LMEAN: begin cmd = CMD_LMEAN; state_next = ST_LSQ; end
            ST_LSQ:   begin cmd = CMD_LSQ;   state_next = ST_LEMIT; end
            ST_LEMIT: begin
                if (!status.out_busy) begin
                    cmd        = CMD_LEMIT;
                    state_next = status.eos ? ST_SDIV : ST_IDLE;
                end
            end
            ST_SDIV: begin cmd = CMD_SDIV; state_next = ST_SWAIT; end
            ST_SWAIT: begin
                if (status.div_done) state_next = ST_SMEAN;
            end
            ST_SMEAN: begin cmd = CMD_SMEAN; state_next = ST_SNN; end
            ST_SNN:   begin cmd = CMD_SNN;   state_next = ST_SP0; end
            ST_SP0:   begin cmd = CMD_SP0;   state_next = ST_SP1; end
            ST_SP1:   begin cmd = CMD_SP1;   state_next = ST_SP2; end
            ST_SP2:   begin cmd = CMD_SP2;   state_next = ST_SS1; end
            ST_SS1:   begin cmd = CMD_SS1;   state_next = ST_SS2; end
            ST_SS2:   begin cmd = CMD_SS2;   state_next = ST_SS3; end
            ST_SS3:   begin cmd = CMD_SS3;   state_next = ST_SDIV2; end
            ST_SDIV2: begin cmd = CMD_SDIV2; state_next = ST_SWAIT2; end
            ST_SWAIT2: begin
                if (status.div_done) state_next = ST_SSQ;
            end
            ST_SSQ: begin cmd = CMD_SSQRT; state_next = ST_SWAIT3; end
            ST_SWAIT3: begin
                if (status.sqrt_done) state_next = ST_SEMIT;
            end
            ST_SEMIT: begin
                if (!status.out_busy) begin
                    cmd        = CMD_SEMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/ppes_dp.sv
module ppes_dp
    import ppes_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output dp_status_t           status,
    input  logic [COORD_W-1:0]   proj_x,
    input  logic [COORD_W-1:0]   proj_y,
    input  logic [COORD_W-1:0]   truth_x,
    input  logic [COORD_W-1:0]   truth_y,
    input  logic                 end_of_line,
    input  logic                 end_of_set,
    input  logic                 cfg_we,
    input  logic [GSD_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           out_kind,
    output logic [VAL_W-1:0]     out_a,
    output logic [VAL_W-1:0]     out_b,
    output logic [CNT_OUT_W-1:0] out_c,
    output logic                 out_err,
    output logic                 out_last
);

    logic [GSD_W-1:0]   gsd_reg;
    logic [DIFF_W-1:0]  dx_reg, dy_reg;
    logic               eol_reg, eos_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [63:0]        mul_reg;
    logic [MEAN_W-1:0]  mean_reg;
    logic [SSUM_W-1:0]  smean_reg;
    logic [DIVD_W-1:0]  nn_reg;

    logic [LSUM_W-1:0]  lsum_reg, lsum_next;
    logic [LCNT_W-1:0]  lcnt_reg, lcnt_next;
    logic [SSUM_W-1:0]  ssum_reg, ssum_next;
    logic [SQSUM_W-1:0] sqsum_reg, sqsum_next;
    logic [SCNT_W-1:0]  scnt_reg, scnt_next;
    logic               ovf_reg, ovf_next;

    logic               ov_reg;
    logic [1:0]         ok_reg;
    logic [VAL_W-1:0]   oa_reg, ob_reg;
    logic [CNT_OUT_W-1:0] oc_reg;
    logic               oe_reg, ol_reg;

    logic [31:0]        mul_a, mul_b;
    logic [DIFF_W-1:0]  ax, ay;
    logic               div_start, sqrt_start, div_done, sqrt_done;
    logic [DIVN_W-1:0]  div_n, quot;
    logic [DIVD_W-1:0]  div_d;
    logic [RAD_W-1:0]   rad;
    logic [ROOT_W-1:0]  root;
    logic [ACC_W-1:0]   mul_ext;

    logic               pt_full, dropped;
    logic [LSUM_W:0]    lsum_add;
    logic [SSUM_W:0]    ssum_add;
    logic [SQSUM_W:0]   sq_add;
    logic               sq_big;
    logic [SQSUM_W-1:0] sq_val;
    logic               set_ge2;

    assign ax      = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : dx_reg;
    assign ay      = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : dy_reg;
    assign mul_ext = {{(ACC_W-64){1'b0}}, mul_reg};
    assign set_ge2 = scnt_reg >= SCNT_W'(2);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd)
            CMD_PMX: begin mul_a = 32'(ax); mul_b = 32'(ax); end
            CMD_PMY: begin mul_a = 32'(ay); mul_b = 32'(ay); end
            CMD_LM0: begin mul_a = 32'(lsum_reg[19:0]);  mul_b = 32'(gsd_reg); end
            CMD_LM1: begin mul_a = 32'(lsum_reg[39:20]); mul_b = 32'(gsd_reg); end
            CMD_LSQ: begin mul_a = mean_reg[31:0]; mul_b = mean_reg[31:0]; end
            CMD_SNN: begin mul_a = 32'(scnt_reg); mul_b = 32'(SCNT_W'(scnt_reg - 1'b1)); end
            CMD_SP0: begin mul_a = sqsum_reg[31:0];  mul_b = 32'(scnt_reg); end
            CMD_SP1: begin mul_a = sqsum_reg[63:32]; mul_b = 32'(scnt_reg); end
            CMD_SP2: begin mul_a = 32'(ssum_reg[23:0]);  mul_b = 32'(ssum_reg[23:0]); end
            CMD_SS1: begin mul_a = 32'(ssum_reg[23:0]);  mul_b = 32'(ssum_reg[47:24]); end
            CMD_SS2: begin mul_a = 32'(ssum_reg[47:24]); mul_b = 32'(ssum_reg[47:24]); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // unit launch operands
    always_comb begin
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        div_n      = '0;
        div_d      = '0;
        rad        = '0;
        unique case (cmd)
            CMD_PSQRT: begin sqrt_start = 1'b1; rad = acc_reg[RAD_W-1:0]; end
            CMD_LDIV: begin
                div_start = 1'b1;
                div_n     = acc_reg[DIVN_W-1:0];
                div_d     = DIVD_W'(lcnt_reg);
            end
            CMD_SDIV: begin
                div_start = 1'b1;
                div_n     = DIVN_W'(ssum_reg);
                div_d     = DIVD_W'(scnt_reg);
            end
            CMD_SDIV2: begin
                div_start = 1'b1;
                div_n     = (acc_reg[ACC_W-1] || !set_ge2) ? '0 : acc_reg[DIVN_W-1:0];
                div_d     = set_ge2 ? nn_reg : DIVD_W'(1);
            end
            CMD_SSQRT: begin
                sqrt_start = 1'b1;
                rad        = (|quot[DIVN_W-1:RAD_W]) ? '1 : quot[RAD_W-1:0];
            end
            default: begin div_start = 1'b0; sqrt_start = 1'b0; end
        endcase
    end

    // accumulation state updates
    always_comb begin
        lsum_next  = lsum_reg;
        lcnt_next  = lcnt_reg;
        ssum_next  = ssum_reg;
        sqsum_next = sqsum_reg;
        scnt_next  = scnt_reg;
        ovf_next   = ovf_reg;
        pt_full    = lcnt_reg >= LCNT_W'(MAX_POINTS_PER_LINE);
        dropped    = 1'b0;
        lsum_add   = {1'b0, lsum_reg} + (LSUM_W+1)'(root);
        ssum_add   = {1'b0, ssum_reg} + (SSUM_W+1)'(mean_reg);
        sq_big     = |mean_reg[MEAN_W-1:32];
        sq_val     = sq_big ? '1 : mul_reg;
        sq_add     = {1'b0, sqsum_reg} + {1'b0, sq_val};
        unique case (cmd)
            CMD_PEMIT: begin
                if (pt_full) begin
                    dropped  = 1'b1;
                    ovf_next = 1'b1;
                end else begin
                    lcnt_next = lcnt_reg + 1'b1;
                    if (lsum_add[LSUM_W]) begin
                        lsum_next = '1;
                        ovf_next  = 1'b1;
                    end else begin
                        lsum_next = lsum_add[LSUM_W-1:0];
                    end
                end
            end
            CMD_LEMIT: begin
                lsum_next = '0;
                lcnt_next = '0;
                if (scnt_reg >= SCNT_W'(MAX_LINES)) begin
                    ovf_next = 1'b1;
                end else begin
                    scnt_next = scnt_reg + 1'b1;
                    if (ssum_add[SSUM_W]) begin
                        ssum_next = '1;
                        ovf_next  = 1'b1;
                    end else begin
                        ssum_next = ssum_add[SSUM_W-1:0];
                    end
                    if (sq_big || sq_add[SQSUM_W]) begin
                        sqsum_next = '1;
                        ovf_next   = 1'b1;
                    end else begin
                        sqsum_next = sq_add[SQSUM_W-1:0];
                    end
                end
            end
            CMD_SEMIT: begin
                ssum_next  = '0;
                sqsum_next = '0;
                scnt_next  = '0;
                ovf_next   = 1'b0;
            end
            default: ovf_next = ovf_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gsd_reg   <= GSD_RESET;
            lsum_reg  <= '0;
            lcnt_reg  <= '0;
            ssum_reg  <= '0;
            sqsum_reg <= '0;
            scnt_reg  <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            if (cfg_we) gsd_reg <= cfg_data;
            lsum_reg  <= lsum_next;
            lcnt_reg  <= lcnt_next;
            ssum_reg  <= ssum_next;
            sqsum_reg <= sqsum_next;
            scnt_reg  <= scnt_next;
            ovf_reg   <= ovf_next;
            if (cmd == CMD_PEMIT || cmd == CMD_LEMIT || cmd == CMD_SEMIT) begin
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge aclk) begin
        // product held while the sequencer waits
        if (cmd != CMD_NOP) mul_reg <= 64'(mul_a) * 64'(mul_b);
        case (cmd)
            CMD_LOAD: begin
                dx_reg  <= {proj_x[COORD_W-1], proj_x} - {truth_x[COORD_W-1], truth_x};
                dy_reg  <= {proj_y[COORD_W-1], proj_y} - {truth_y[COORD_W-1], truth_y};
                eol_reg <= end_of_line;
                eos_reg <= end_of_line & end_of_set;
            end
            CMD_PMX, CMD_SNN: acc_reg <= '0;
            CMD_PMY, CMD_LM1: acc_reg <= mul_ext;
            CMD_PMA, CMD_SP1: acc_reg <= acc_reg + mul_ext;
            CMD_LM2: acc_reg <= acc_reg + (mul_ext << 20);
            CMD_LMEAN: begin
                mean_reg <= (|quot[DIVN_W-1:MEAN_W+16]) ? '1 : quot[MEAN_W+15:16];
            end
            CMD_SMEAN: smean_reg <= (scnt_reg == '0) ? '0 : quot[SSUM_W-1:0];
            CMD_SP0: nn_reg <= mul_reg[DIVD_W-1:0];
            CMD_SP2: acc_reg <= acc_reg + (mul_ext << 32);
            CMD_SS1: acc_reg <= acc_reg - mul_ext;
            CMD_SS2: acc_reg <= acc_reg - (mul_ext << 25);
            CMD_SS3: acc_reg <= acc_reg - (mul_ext << 48);
            CMD_PEMIT: begin
                ok_reg <= KIND_POINT;
                oa_reg <= VAL_W'($signed(dx_reg));
                ob_reg <= VAL_W'($signed(dy_reg));
                oc_reg <= CNT_OUT_W'(root);
                oe_reg <= dropped;
                ol_reg <= ~eol_reg;
            end
            CMD_LEMIT: begin
                ok_reg <= KIND_LINE;
                oa_reg <= VAL_W'(mean_reg);
                ob_reg <= '0;
                oc_reg <= CNT_OUT_W'(lcnt_reg);
                oe_reg <= ovf_next;
                ol_reg <= ~eos_reg;
            end
            CMD_SEMIT: begin
                ok_reg <= KIND_SET;
                oa_reg <= smean_reg;
                ob_reg <= VAL_W'(root);
                oc_reg <= CNT_OUT_W'(scnt_reg);
                oe_reg <= ovf_reg | (scnt_reg == SCNT_W'(1));
                ol_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    ppes_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (quot)
    );

    ppes_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (rad),
        .done     (sqrt_done),
        .root     (root)
    );

    assign status.sqrt_done = sqrt_done;
    assign status.div_done  = div_done;
    assign status.out_busy  = ov_reg;
    assign status.eol       = eol_reg;
    assign status.eos       = eos_reg;

    assign out_valid = ov_reg;
    assign out_kind  = ok_reg;
    assign out_a     = oa_reg;
    assign out_b     = ob_reg;
    assign out_c     = oc_reg;
    assign out_err   = oe_reg;
    assign out_last  = ol_reg;

endmodule

FILE: rtl/paired_point_error_statistics_core.sv
// point word: two squares and a 32-step square root from accept to result
// line end adds an 80-step divider pass (one bit a cycle); set end adds two more
// divider passes and one square root; next word accepted once the last
// result of the word is loaded into the output register
// one word in flight at a time; pace set by the shared divider and square root units
// aresetn synchronous active low: clears sums, counts, flags, sets gsd_scale to 1.0
module paired_point_error_statistics_core
    import ppes_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // input words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // proj_x, proj_y, truth_x, truth_y
    input  logic         s_tlast,   // end_of_line
    input  logic         s_tuser,   // end_of_set
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // value_a, value_b, value_c, error
    output logic         m_tlast,   // last
    output logic [1:0]   m_tuser,   // kind
    // gsd_scale register write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [23:0]  cfg_data
);

    cmd_t       cmd;
    dp_status_t status;

    logic [VAL_W-1:0]     out_a, out_b;
    logic [CNT_OUT_W-1:0] out_c;
    logic                 out_err;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer: one command per cycle into the datapath, NOP while waiting on a unit or the output register
    ppes_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, accumulators and the result register
    ppes_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .proj_x      (s_tdata[23:0]),
        .proj_y      (s_tdata[47:24]),
        .truth_x     (s_tdata[71:48]),
        .truth_y     (s_tdata[95:72]),
        .end_of_line (s_tlast),
        .end_of_set  (s_tuser),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_a       (out_a),
        .out_b       (out_b),
        .out_c       (out_c),
        .out_err     (out_err),
        .out_last    (m_tlast)
    );

    // pack result fields, lowest first
    assign m_tdata = {out_err, out_c, out_b, out_a};

endmodule
